### rtl/lgg_pkg.sv
// ----------------------------------------------------------------------------
// lgg_pkg
// Shared sizes, codes and types of the life generation grid: grid geometry,
// register indexes, operation codes and the three-row window type.
// ----------------------------------------------------------------------------
package lgg_pkg;

    // grid geometry
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);

    // command field widths
    localparam int CMD_ROW_W = 6;
    localparam int CMD_COL_W = 6;
    localparam int OP_W      = 2;

    // configuration registers
    localparam int REG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam logic [REG_W-1:0] REG_RESET = REG_W'(10);
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

    // widths that hold a row or column count up to the maximum or a register value
    localparam int RCNT_W = (REG_W > ROW_W + 1) ? REG_W : ROW_W + 1;
    localparam int CCNT_W = (REG_W > COL_W + 1) ? REG_W : COL_W + 1;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_ADVANCE = 2'd2
    } op_t;

    // one grid row, one bit per column
    typedef logic [MAX_COLS-1:0] row_bits_t;

    // rows above, at and below the row being updated (old generation)
    typedef struct packed {
        row_bits_t prev;
        row_bits_t cur;
        row_bits_t next;
    } row_window_t;

endpackage

### rtl/lgg_ram.sv
// ----------------------------------------------------------------------------
// lgg_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lgg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### rtl/lgg_row_update.sv
// ----------------------------------------------------------------------------
// lgg_row_update
// Next generation of one grid row by the B3/S23 rule, one lane per column,
// from the old rows above, at and below it; columns outside the mask keep
// their value and count as dead neighbors.
// ----------------------------------------------------------------------------
module lgg_row_update (
    input  lgg_pkg::row_window_t win,
    input  lgg_pkg::row_bits_t   col_mask,
    output lgg_pkg::row_bits_t   new_row
);
    import lgg_pkg::*;

    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] STAY_COUNT  = 4'd2;

    logic [MAX_COLS+1:0] p_pad;
    logic [MAX_COLS+1:0] c_pad;
    logic [MAX_COLS+1:0] n_pad;
    logic [3:0]          cnt [MAX_COLS];

    // zero-padded masked rows, so edge columns see dead neighbors
    always_comb
    begin
        p_pad = {1'b0, win.prev & col_mask, 1'b0};
        c_pad = {1'b0, win.cur  & col_mask, 1'b0};
        n_pad = {1'b0, win.next & col_mask, 1'b0};
    end

    // neighbor count and rule, per column
    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            cnt[c] = 4'(p_pad[c]) + 4'(p_pad[c+1]) + 4'(p_pad[c+2])
                   + 4'(c_pad[c]) + 4'(c_pad[c+2])
                   + 4'(n_pad[c]) + 4'(n_pad[c+1]) + 4'(n_pad[c+2]);
            if (col_mask[c])
            begin
                new_row[c] = (cnt[c] == BIRTH_COUNT) || (win.cur[c] && cnt[c] == STAY_COUNT);
            end
            else
            begin
                new_row[c] = win.cur[c];
            end
        end
    end

endmodule

### rtl/life_generation_grid_core.sv
// ----------------------------------------------------------------------------
// life_generation_grid_core
// Grid of live/dead cells with cell write, cell read and B3/S23 generation
// step, stored one row per RAM word.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all MAX_ROWS rows with busy
// high; configuration writes are taken during it. A command is taken when
// start is high and busy is low. A cell write or read passes through ST_CELL;
// done then pulses for one cycle, with cell_alive valid only in that cycle,
// and the next command can be taken while done is high. An advance loads the
// first row in ST_ADV_LOAD, then writes one row per cycle in ST_ADV_ROW
// for each row in use (saturated at MAX_ROWS), set by the single row read
// and row write the RAM gives each cycle. The receiver cannot stall: done
// is a one-cycle strobe and the result is lost if not captured. cfg_ready is
// always high; registers may be written only while no command is in flight.
module life_generation_grid_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  logic [lgg_pkg::OP_W-1:0]       operation,
    input  logic [lgg_pkg::CMD_ROW_W-1:0]  row,
    input  logic [lgg_pkg::CMD_COL_W-1:0]  col,
    input  logic                           cell_value,
    // result
    output logic                           done,
    output logic                           cell_alive,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lgg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lgg_pkg::REG_W-1:0]      cfg_data
);
    import lgg_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL,
        ST_ADV_LOAD,
        ST_ADV_ROW
    } state_t;

    state_t               state_reg, state_next;
    logic [REG_W-1:0]     rows_reg, rows_next;
    logic [REG_W-1:0]     cols_reg, cols_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [CMD_ROW_W-1:0] cmd_row_reg, cmd_row_next;
    logic [CMD_COL_W-1:0] cmd_col_reg, cmd_col_next;
    logic                 cmd_val_reg, cmd_val_next;
    logic [ROW_W-1:0]     sweep_reg, sweep_next;
    row_bits_t            prev_reg, prev_next;
    row_bits_t            cur_reg, cur_next;
    logic                 done_reg, done_next;
    logic                 alive_reg, alive_next;

    logic [RCNT_W-1:0]    rows_eff;
    logic [CCNT_W-1:0]    cols_eff;
    logic [RCNT_W-1:0]    rows_ext;
    logic [CCNT_W-1:0]    cols_ext;
    logic [RCNT_W-1:0]    sweep_plus1;
    row_bits_t            col_mask;
    logic                 cmd_inside;
    logic [COL_W-1:0]     col_idx;
    logic                 next_valid;
    row_bits_t            next_bits;
    row_bits_t            patched;
    row_bits_t            new_row;
    row_window_t          win;

    logic                 ram_we;
    logic [ROW_W-1:0]     ram_waddr;
    row_bits_t            ram_wdata;
    logic [ROW_W-1:0]     ram_raddr;
    row_bits_t            ram_rdata;

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign cell_alive = alive_reg;
    assign cfg_ready  = 1'b1;

    // grid rows, one word per row
    lgg_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // saturated region in use
    always_comb
    begin
        rows_ext = RCNT_W'(rows_reg);
        cols_ext = CCNT_W'(cols_reg);
        rows_eff = (rows_ext > RCNT_W'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS) : rows_ext;
        cols_eff = (cols_ext > CCNT_W'(MAX_COLS)) ? CCNT_W'(MAX_COLS) : cols_ext;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_mask[c] = (CCNT_W'(c) < cols_eff);
        end
    end

    // latched command decode
    always_comb
    begin
        cmd_inside = (RCNT_W'(cmd_row_reg) < rows_eff) && (CCNT_W'(cmd_col_reg) < cols_eff);
        col_idx    = COL_W'(cmd_col_reg);
        for (int c = 0; c < MAX_COLS; c++)
        begin
            patched[c] = (COL_W'(c) == col_idx) ? cmd_val_reg : ram_rdata[c];
        end
    end

    // advance window: row below is dead past the last row in use
    always_comb
    begin
        sweep_plus1 = RCNT_W'(sweep_reg) + RCNT_W'(1);
        next_valid  = (sweep_plus1 < rows_eff);
        next_bits   = next_valid ? ram_rdata : '0;
        win.prev    = prev_reg;
        win.cur     = cur_reg;
        win.next    = next_bits;
    end

    lgg_row_update u_row_update (
        .win      (win),
        .col_mask (col_mask),
        .new_row  (new_row)
    );

    // sequencer and register writes
    always_comb
    begin
        state_next   = state_reg;
        rows_next    = rows_reg;
        cols_next    = cols_reg;
        op_next      = op_reg;
        cmd_row_next = cmd_row_reg;
        cmd_col_next = cmd_col_reg;
        cmd_val_next = cmd_val_reg;
        sweep_next   = sweep_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        done_next    = 1'b0;
        alive_next   = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = sweep_reg;
        ram_wdata    = new_row;
        ram_raddr    = ROW_W'(RCNT_W'(sweep_reg) + RCNT_W'(2));

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROWS: rows_next = cfg_data;
                REG_COLS: cols_next = cfg_data;
                default:  ;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (sweep_reg == ROW_W'(MAX_ROWS - 1))
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + ROW_W'(1);
                end
            end
            ST_IDLE:
            begin
                ram_raddr = (operation == OP_ADVANCE) ? '0 : ROW_W'(row);
                if (start)
                begin
                    op_next      = operation;
                    cmd_row_next = row;
                    cmd_col_next = col;
                    cmd_val_next = cell_value;
                    state_next   = (operation == OP_ADVANCE) ? ST_ADV_LOAD : ST_CELL;
                end
            end
            ST_CELL:
            begin
                if (op_reg == OP_WRITE && cmd_inside)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ROW_W'(cmd_row_reg);
                    ram_wdata = patched;
                end
                if (op_reg == OP_READ && cmd_inside)
                begin
                    alive_next = ram_rdata[col_idx];
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_ADV_LOAD:
            begin
                prev_next  = '0;
                cur_next   = ram_rdata;
                sweep_next = '0;
                ram_raddr  = ROW_W'(1);
                if (rows_eff == '0)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ADV_ROW;
                end
            end
            ST_ADV_ROW:
            begin
                ram_we    = 1'b1;
                prev_next = cur_reg;
                cur_next  = next_bits;
                if (!next_valid)
                begin
                    done_next  = 1'b1;
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + ROW_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, registers and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            rows_reg    <= REG_RESET;
            cols_reg    <= REG_RESET;
            op_reg      <= '0;
            cmd_row_reg <= '0;
            cmd_col_reg <= '0;
            cmd_val_reg <= 1'b0;
            sweep_reg   <= '0;
            prev_reg    <= '0;
            cur_reg     <= '0;
            done_reg    <= 1'b0;
            alive_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rows_reg    <= rows_next;
            cols_reg    <= cols_next;
            op_reg      <= op_next;
            cmd_row_reg <= cmd_row_next;
            cmd_col_reg <= cmd_col_next;
            cmd_val_reg <= cmd_val_next;
            sweep_reg   <= sweep_next;
            prev_reg    <= prev_next;
            cur_reg     <= cur_next;
            done_reg    <= done_next;
            alive_reg   <= alive_next;
        end
    end

endmodule

### rtl/lgg_checker.sv
// ----------------------------------------------------------------------------
// lgg_checker
// Port-level checks of the life generation grid core, bound to the top level.
// ----------------------------------------------------------------------------
module lgg_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cell_alive
);

    // an accepted command keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("command accepted but block not busy afterwards");

    // result strobe lasts a single cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for more than one cycle");

    // a result follows a cycle of work
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("done without a command in flight");

    // cell_alive only shows with the strobe
    assert property (@(posedge clk) disable iff (!rst_n) !done |-> !cell_alive)
        else $error("cell_alive high outside a result beat");

endmodule

bind life_generation_grid_core lgg_checker u_lgg_checker (.*);
